// ===== rtl/nalus_pkg.sv =====
// ----------------------------------------------------------------------------
// nalus_pkg
// shared types and constants of the h.264 nal unit splitter
// ----------------------------------------------------------------------------
`default_nettype none

package nalus_pkg;

    // frame and table limits
    localparam int MAX_NALUS       = 16;
    localparam int MAX_FRAME_BYTES = 1048576;

    // internal widths follow from the limits
    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CNT_W = $clog2(MAX_NALUS + 1);

    // fixed widths of the result fields
    localparam int OFF_W      = 20;
    localparam int LEN_W      = 21;
    localparam int TYPE_W     = 5;
    localparam int CNT_OUT_W  = 5;
    localparam int STATUS_W   = 2;

    // nal unit types of interest
    localparam logic [TYPE_W-1:0] NAL_NON_IDR = 5'd1;
    localparam logic [TYPE_W-1:0] NAL_IDR     = 5'd5;
    localparam logic [TYPE_W-1:0] NAL_SEI     = 5'd6;
    localparam logic [TYPE_W-1:0] NAL_SPS     = 5'd7;

    // frame status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_START = 2'd2;

    // parse phases
    typedef enum logic [2:0] {
        PHASE_LEAD,
        PHASE_HEADER,
        PHASE_BODY,
        PHASE_VCL,
        PHASE_STOP
    } phase_t;

endpackage

`default_nettype wire

// ===== rtl/nalus_in_if.sv =====
// ----------------------------------------------------------------------------
// nalus_in_if
// byte channel: one frame byte per item with a last-byte mark
// ----------------------------------------------------------------------------
`default_nettype none

interface nalus_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

`default_nettype wire

// ===== rtl/nalus_out_if.sv =====
// ----------------------------------------------------------------------------
// nalus_out_if
// result channel: nal unit records and frame summaries
// ----------------------------------------------------------------------------
`default_nettype none

interface nalus_out_if;

    logic                               valid;
    logic                               ready;
    logic                               unit_valid;
    logic [nalus_pkg::OFF_W-1:0]        unit_offset;
    logic [nalus_pkg::LEN_W-1:0]        unit_length;
    logic [nalus_pkg::TYPE_W-1:0]       unit_type;
    logic                               frame_end;
    logic [nalus_pkg::STATUS_W-1:0]     frame_status;
    logic                               key_frame;
    logic [nalus_pkg::CNT_OUT_W-1:0]    unit_count;
    logic                               table_full;

    modport source (
        output valid, input ready,
        output unit_valid, output unit_offset, output unit_length, output unit_type,
        output frame_end, output frame_status, output key_frame, output unit_count,
        output table_full
    );
    modport sink (
        input valid, output ready,
        input unit_valid, input unit_offset, input unit_length, input unit_type,
        input frame_end, input frame_status, input key_frame, input unit_count,
        input table_full
    );

endinterface

`default_nettype wire

// ===== rtl/h264_nal_unit_splitter_top.sv =====
// ----------------------------------------------------------------------------
// h264_nal_unit_splitter_top
// splits an annex b frame into nal unit records, one byte per item
// ----------------------------------------------------------------------------
// usage:
//   frame_bytes  carries the frame one byte per item, last_byte on the final
//                byte; the frame must open with the start code 00 00 00 01
//   unit_records carries one item per kept unit and one closing item per
//                frame (frame_end set, with status, key mark and unit count)
//   a unit ending at a start code is reported in the cycle after the 01 byte of
//   that start code is taken; a unit open at the final byte is reported on
//   the closing item
//   throughput is one byte per cycle while the receiver takes each waiting
//   item, set by the single parse state update and the output register
//   when the receiver stalls a waiting item, frame_bytes ready drops until
//   the item is taken; bytes already taken are never lost
//   reset clears the parse state and empties the output register; the state
//   also clears itself after every final byte
// ----------------------------------------------------------------------------
`default_nettype none

module h264_nal_unit_splitter_top (
    input  wire             clk,
    input  wire             rst_n,
    nalus_in_if.sink        frame_bytes,
    nalus_out_if.source     unit_records
);

    localparam int POS_W = nalus_pkg::POS_W;
    localparam int CNT_W = nalus_pkg::CNT_W;

    // parse state
    logic [POS_W-1:0]               pos_reg, pos_next;
    nalus_pkg::phase_t              phase_reg, phase_next;
    logic [23:0]                    window_reg, window_next;
    logic [1:0]                     seen_reg, seen_next;
    logic [nalus_pkg::OFF_W-1:0]    off_reg, off_next;
    logic [POS_W-1:0]               len_reg, len_next;
    logic [nalus_pkg::TYPE_W-1:0]   type_reg, type_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic                           key_reg, key_next;
    logic                           full_reg, full_next;
    logic                           bad_reg, bad_next;

    // output register
    logic                               out_valid_reg;
    logic                               unit_valid_reg, unit_valid_next;
    logic [nalus_pkg::OFF_W-1:0]        unit_offset_reg, unit_offset_next;
    logic [nalus_pkg::LEN_W-1:0]        unit_length_reg, unit_length_next;
    logic [nalus_pkg::TYPE_W-1:0]       unit_type_reg, unit_type_next;
    logic                               frame_end_reg, frame_end_next;
    logic [nalus_pkg::STATUS_W-1:0]     frame_status_reg, frame_status_next;
    logic                               key_frame_reg, key_frame_next;
    logic [nalus_pkg::CNT_OUT_W-1:0]    unit_count_reg, unit_count_next;
    logic                               table_full_reg, table_full_next;

    logic                   in_fire;
    logic                   emit;
    logic [7:0]             b;
    logic                   last;

    // intermediate values after the byte is parsed
    nalus_pkg::phase_t              phase_mid;
    logic [POS_W-1:0]               pos_mid;
    logic [POS_W-1:0]               len_mid;
    logic [POS_W-1:0]               len_inc;
    logic [nalus_pkg::TYPE_W-1:0]   type_mid;
    logic [nalus_pkg::OFF_W-1:0]    off_mid;
    logic                           bad_mid;
    logic                           body_keep;
    logic                           end_keep;
    logic                           keep_en;
    logic [POS_W-1:0]               keep_len;
    logic [CNT_W-1:0]               count_inc;
    logic                           key_mid;
    logic                           full_mid;
    nalus_pkg::phase_t              phase_keep;
    logic [nalus_pkg::STATUS_W-1:0] status;
    logic [7:0]                     lead_expect;

    assign b       = frame_bytes.data_byte;
    assign last    = frame_bytes.last_byte;
    assign frame_bytes.ready = !out_valid_reg || unit_records.ready;
    assign in_fire = frame_bytes.valid && frame_bytes.ready;

    assign len_inc     = len_reg + POS_W'(1);
    assign lead_expect = (pos_reg == POS_W'(3)) ? 8'd1 : 8'd0;
    assign count_inc   = count_reg + CNT_W'(1);

    // byte parse
    always_comb
    begin
        phase_mid   = phase_reg;
        pos_mid     = pos_reg;
        len_mid     = len_reg;
        type_mid    = type_reg;
        off_mid     = off_reg;
        bad_mid     = bad_reg;
        window_next = window_reg;
        seen_next   = seen_reg;
        body_keep   = 1'b0;
        if (pos_reg < POS_W'(nalus_pkg::MAX_FRAME_BYTES))
        begin
            pos_mid = pos_reg + POS_W'(1);
            unique case (phase_reg)
                nalus_pkg::PHASE_LEAD:
                begin
                    bad_mid = bad_reg || (b != lead_expect);
                    if (pos_reg >= POS_W'(3))
                    begin
                        phase_mid = bad_mid ? nalus_pkg::PHASE_STOP : nalus_pkg::PHASE_HEADER;
                    end
                end
                nalus_pkg::PHASE_HEADER:
                begin
                    type_mid = b[nalus_pkg::TYPE_W-1:0];
                    off_mid  = nalus_pkg::OFF_W'(pos_reg);
                    len_mid  = POS_W'(1);
                    if (type_mid == nalus_pkg::NAL_NON_IDR || type_mid == nalus_pkg::NAL_IDR)
                    begin
                        phase_mid = nalus_pkg::PHASE_VCL;
                    end
                    else
                    begin
                        phase_mid   = nalus_pkg::PHASE_BODY;
                        window_next = 24'd0;
                        seen_next   = 2'd0;
                    end
                end
                nalus_pkg::PHASE_BODY:
                begin
                    len_mid = len_inc;
                    if (seen_reg == 2'd3 && window_reg == 24'd0 && b == 8'd1)
                    begin
                        phase_mid = nalus_pkg::PHASE_HEADER;
                        body_keep = (type_reg != nalus_pkg::NAL_SEI);
                    end
                    else
                    begin
                        window_next = {window_reg[15:0], b};
                        if (seen_reg != 2'd3)
                        begin
                            seen_next = seen_reg + 2'd1;
                        end
                    end
                end
                nalus_pkg::PHASE_VCL:
                begin
                    len_mid = len_inc;
                end
                default:
                begin
                end
            endcase
        end
    end

    // unit keep and frame close
    always_comb
    begin
        end_keep = last && !body_keep &&
                   ((phase_mid == nalus_pkg::PHASE_BODY && type_mid != nalus_pkg::NAL_SEI) ||
                    phase_mid == nalus_pkg::PHASE_VCL);
        keep_en  = body_keep || end_keep;
        keep_len = body_keep ? (len_mid - POS_W'(4)) : len_mid;

        count_next = count_reg;
        key_mid    = key_reg;
        full_mid   = full_reg;
        phase_keep = phase_mid;
        if (keep_en)
        begin
            count_next = count_inc;
            if (type_mid == nalus_pkg::NAL_SPS)
            begin
                key_mid = 1'b1;
            end
            if (count_inc >= CNT_W'(nalus_pkg::MAX_NALUS))
            begin
                full_mid   = 1'b1;
                phase_keep = nalus_pkg::PHASE_STOP;
            end
        end

        if (pos_mid < POS_W'(5))
        begin
            status = nalus_pkg::STATUS_SHORT;
        end
        else if (bad_mid)
        begin
            status = nalus_pkg::STATUS_NO_START;
        end
        else
        begin
            status = nalus_pkg::STATUS_OK;
        end

        emit = keep_en || last;

        if (last && status != nalus_pkg::STATUS_OK)
        begin
            unit_valid_next   = 1'b0;
            unit_offset_next  = '0;
            unit_length_next  = '0;
            unit_type_next    = '0;
            frame_end_next    = 1'b1;
            frame_status_next = status;
            key_frame_next    = 1'b0;
            unit_count_next   = '0;
            table_full_next   = 1'b0;
        end
        else
        begin
            unit_valid_next   = keep_en;
            unit_offset_next  = keep_en ? off_mid : '0;
            unit_length_next  = keep_en ? nalus_pkg::LEN_W'(keep_len) : '0;
            unit_type_next    = keep_en ? type_mid : '0;
            frame_end_next    = last;
            frame_status_next = nalus_pkg::STATUS_OK;
            key_frame_next    = key_mid;
            unit_count_next   = nalus_pkg::CNT_OUT_W'(count_next);
            table_full_next   = full_mid;
        end

        // clear everything after the final byte
        if (last)
        begin
            pos_next   = '0;
            phase_next = nalus_pkg::PHASE_LEAD;
            len_next   = '0;
            type_next  = '0;
            off_next   = '0;
            bad_next   = 1'b0;
            key_next   = 1'b0;
            full_next  = 1'b0;
            count_next = '0;
        end
        else
        begin
            pos_next   = pos_mid;
            phase_next = phase_keep;
            len_next   = len_mid;
            type_next  = type_mid;
            off_next   = off_mid;
            bad_next   = bad_mid;
            key_next   = key_mid;
            full_next  = full_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            phase_reg  <= nalus_pkg::PHASE_LEAD;
            window_reg <= '0;
            seen_reg   <= '0;
            off_reg    <= '0;
            len_reg    <= '0;
            type_reg   <= '0;
            count_reg  <= '0;
            key_reg    <= 1'b0;
            full_reg   <= 1'b0;
            bad_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            window_reg <= last ? 24'd0 : window_next;
            seen_reg   <= last ? 2'd0 : seen_next;
            off_reg    <= off_next;
            len_reg    <= len_next;
            type_reg   <= type_next;
            count_reg  <= count_next;
            key_reg    <= key_next;
            full_reg   <= full_next;
            bad_reg    <= bad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= emit;
        end
        else if (unit_records.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            unit_valid_reg   <= unit_valid_next;
            unit_offset_reg  <= unit_offset_next;
            unit_length_reg  <= unit_length_next;
            unit_type_reg    <= unit_type_next;
            frame_end_reg    <= frame_end_next;
            frame_status_reg <= frame_status_next;
            key_frame_reg    <= key_frame_next;
            unit_count_reg   <= unit_count_next;
            table_full_reg   <= table_full_next;
        end
    end

    assign unit_records.valid        = out_valid_reg;
    assign unit_records.unit_valid   = unit_valid_reg;
    assign unit_records.unit_offset  = unit_offset_reg;
    assign unit_records.unit_length  = unit_length_reg;
    assign unit_records.unit_type    = unit_type_reg;
    assign unit_records.frame_end    = frame_end_reg;
    assign unit_records.frame_status = frame_status_reg;
    assign unit_records.key_frame    = key_frame_reg;
    assign unit_records.unit_count   = unit_count_reg;
    assign unit_records.table_full   = table_full_reg;

endmodule

`default_nettype wire
